// ===== hw/rtl/ams_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amicable pair checker package
// Shared widths, control word layout, step codes and the microcode program.
// ----------------------------------------------------------------------------
package ams_pkg;

  // Default width of one input number and fixed width of a reported sum.
  localparam int NUMBER_BITS_DEF = 17;
  localparam int SUM_OUT_BITS    = 19;

  typedef logic [3:0] step_t;
  typedef logic [2:0] op_t;
  typedef logic [2:0] cond_t;

  // Program step addresses.
  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_DIVGO   = 4'd1;
  localparam step_t S_DIVWAIT = 4'd2;
  localparam step_t S_TEST    = 4'd3;
  localparam step_t S_ADDI    = 4'd4;
  localparam step_t S_ADDQ    = 4'd5;
  localparam step_t S_FIN     = 4'd6;
  localparam step_t S_NEXT    = 4'd7;
  localparam step_t S_EMIT    = 4'd8;

  // Datapath operations.
  localparam op_t OP_NOP   = 3'd0;
  localparam op_t OP_LATCH = 3'd1;
  localparam op_t OP_DIVGO = 3'd2;
  localparam op_t OP_ADD_I = 3'd3;
  localparam op_t OP_ADD_Q = 3'd4;
  localparam op_t OP_SUB_N = 3'd5;
  localparam op_t OP_SWAP  = 3'd6;
  localparam op_t OP_EMIT  = 3'd7;

  // Jump conditions.
  localparam cond_t C_NEVER    = 3'd0;
  localparam cond_t C_ALWAYS   = 3'd1;
  localparam cond_t C_NO_START = 3'd2;
  localparam cond_t C_DIV_BUSY = 3'd3;
  localparam cond_t C_Q_LT_I   = 3'd4;
  localparam cond_t C_FIRST    = 3'd5;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_t;

  // Datapath flags that the sequencer tests.
  typedef struct packed {
    logic start;
    logic div_busy;
    logic q_lt_i;
    logic first;
  } status_t;

  // Microcode program: one control word per step.
  function automatic ctrl_t ucode_rom(input step_t pc);
    ctrl_t cw;
    unique case (pc)
      S_IDLE:    cw = '{op: OP_LATCH, cond: C_NO_START, target: S_IDLE};
      S_DIVGO:   cw = '{op: OP_DIVGO, cond: C_NEVER,    target: S_IDLE};
      S_DIVWAIT: cw = '{op: OP_NOP,   cond: C_DIV_BUSY, target: S_DIVWAIT};
      S_TEST:    cw = '{op: OP_NOP,   cond: C_Q_LT_I,   target: S_FIN};
      S_ADDI:    cw = '{op: OP_ADD_I, cond: C_NEVER,    target: S_IDLE};
      S_ADDQ:    cw = '{op: OP_ADD_Q, cond: C_ALWAYS,   target: S_DIVGO};
      S_FIN:     cw = '{op: OP_SUB_N, cond: C_NEVER,    target: S_IDLE};
      S_NEXT:    cw = '{op: OP_SWAP,  cond: C_FIRST,    target: S_DIVGO};
      S_EMIT:    cw = '{op: OP_EMIT,  cond: C_ALWAYS,   target: S_IDLE};
      default:   cw = '{op: OP_NOP,   cond: C_ALWAYS,   target: S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// ===== hw/rtl/ams_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle, giving quotient and remainder.
// ----------------------------------------------------------------------------
module ams_div #(
  parameter int NUMBER_BITS = 17
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [NUMBER_BITS-1:0] dividend,
  input  logic [NUMBER_BITS-1:0] divisor,
  output logic                   busy,
  output logic [NUMBER_BITS-1:0] quot,
  output logic [NUMBER_BITS-1:0] rem
);

  localparam int CNT_W = $clog2(NUMBER_BITS + 1);

  logic [CNT_W-1:0]       count;
  logic [NUMBER_BITS:0]   trial;
  logic [NUMBER_BITS:0]   diff;

  assign busy = (count != '0);

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign trial = {rem, quot[NUMBER_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  // Bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(NUMBER_BITS);
    end else if (busy) begin
      count <= count - 1'b1;
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      if (!diff[NUMBER_BITS]) begin
        rem  <= diff[NUMBER_BITS-1:0];
        quot <= {quot[NUMBER_BITS-2:0], 1'b1};
      end else begin
        rem  <= trial[NUMBER_BITS-1:0];
        quot <= {quot[NUMBER_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hw/rtl/ams_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the program table, with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module ams_seq
  import ams_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   cw,
  output logic    busy
);

  step_t pc;
  step_t pc_next;
  logic  take;

  assign cw   = ucode_rom(pc);
  assign busy = (pc != S_IDLE);

  // Evaluate the jump condition of the current step.
  always_comb begin
    unique case (cw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_START: take = !status.start;
      C_DIV_BUSY: take = status.div_busy;
      C_Q_LT_I:   take = status.q_lt_i;
      C_FIRST:    take = status.first;
      default:    take = 1'b1;
    endcase
    pc_next = take ? cw.target : pc + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== hw/rtl/amicable_pair_checker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Amicable pair checker
// Sums the proper divisors of two numbers and flags an amicable pair.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; one result follows,
// shown for a single cycle with done high, and the receiver cannot stall it.
// Each number n is worked by trial division over i = 1 .. floor(sqrt(n)) + 1,
// and each trial runs the serial divider, which sets most of the time that an
// item takes. Busy stays high for the whole item, and a new item may be
// started in the cycle that done is high.
module amicable_pair_checker_top
  import ams_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [NUMBER_BITS-1:0]  first_number,
  input  logic [NUMBER_BITS-1:0]  second_number,
  output logic                    done,
  output logic                    is_amicable,
  output logic [SUM_OUT_BITS-1:0] first_divisor_sum,
  output logic [SUM_OUT_BITS-1:0] second_divisor_sum
);

  // The divisor sum stays below eight times the number.
  localparam int SUM_W = NUMBER_BITS + 3;

  ctrl_t   cw;
  status_t status;

  logic [NUMBER_BITS-1:0] num_a;
  logic [NUMBER_BITS-1:0] num_b;
  logic [NUMBER_BITS-1:0] n;
  logic [NUMBER_BITS-1:0] i;
  logic [SUM_W-1:0]       sum;
  logic [SUM_W-1:0]       sum_a;
  logic                   second;

  logic                   div_busy;
  logic [NUMBER_BITS-1:0] div_quot;
  logic [NUMBER_BITS-1:0] div_rem;
  logic                   rem_zero;

  assign rem_zero = (div_rem == '0);

  // Flags for the sequencer.
  assign status.start    = start;
  assign status.div_busy = div_busy;
  assign status.q_lt_i   = (div_quot < i);
  assign status.first    = !second;

  ams_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw),
    .busy   (busy)
  );

  ams_div #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cw.op == OP_DIVGO),
    .dividend (n),
    .divisor  (i),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_LATCH: begin
        if (start) begin
          num_a  <= first_number;
          num_b  <= second_number;
          n      <= first_number;
          i      <= NUMBER_BITS'(1);
          sum    <= '0;
          second <= 1'b0;
        end
      end
      OP_ADD_I: begin
        if (rem_zero) begin
          sum <= sum + SUM_W'(i);
        end
      end
      OP_ADD_Q: begin
        if (rem_zero && (div_quot != i)) begin
          sum <= sum + SUM_W'(div_quot);
        end
        i <= i + 1'b1;
      end
      OP_SUB_N: begin
        if (n != '0) begin
          sum <= sum - SUM_W'(n);
        end
      end
      OP_SWAP: begin
        if (!second) begin
          sum_a  <= sum;
          n      <= num_b;
          i      <= NUMBER_BITS'(1);
          sum    <= '0;
          second <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result registers, written once per item.
  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT) begin
      is_amicable        <= (sum_a == SUM_W'(num_b)) && (sum == SUM_W'(num_a));
      first_divisor_sum  <= SUM_OUT_BITS'(sum_a);
      second_divisor_sum <= SUM_OUT_BITS'(sum);
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cw.op == OP_EMIT);
    end
  end

`ifndef SYNTHESIS
  // The block is idle again when a result is shown.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while an item is still in work");

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  // The result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  // The divider is never restarted while it is still working.
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_DIVGO) |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule
